// File: hw/rtl/mafu_pkg.sv
// Shared types and constants for the multicycle ALU functional unit.
// Used by the front, queue, back, top level and checker; depends on nothing.
package mafu_pkg;

    // Fixed field widths of the request, result and configuration items, and the queue depth
    localparam int OPC_W       = 4;
    localparam int LAT_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OUT_TAG_W   = 16;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_TDATA_W = OUT_TAG_W + OUT_VALUE_W;
    localparam int CFG_ADDR_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    // Opcodes
    localparam logic [OPC_W-1:0] OPC_ADD  = 4'd1;
    localparam logic [OPC_W-1:0] OPC_ADDI = 4'd2;
    localparam logic [OPC_W-1:0] OPC_SUB  = 4'd3;
    localparam logic [OPC_W-1:0] OPC_MUL  = 4'd4;
    localparam logic [OPC_W-1:0] OPC_DIV  = 4'd5;
    localparam logic [OPC_W-1:0] OPC_CMP  = 4'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_OPCODE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUSY       = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SIMPLE_LAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MUL_LAT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIV_LAT    = 2'd2;

    // Latency reset values
    localparam logic [LAT_W-1:0] RST_SIMPLE_LAT = 8'd1;
    localparam logic [LAT_W-1:0] RST_MUL_LAT    = 8'd5;
    localparam logic [LAT_W-1:0] RST_DIV_LAT    = 8'd15;

    // Request class decided by the front
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_BAD,
        KIND_ADD,
        KIND_SUB,
        KIND_CMP,
        KIND_MUL,
        KIND_DIV
    } op_kind_t;

    // Control part of a queued request
    typedef struct packed {
        op_kind_t          kind;
        logic [LAT_W-1:0]  latency;
    } issue_ctrl_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_DISPATCH,
        BK_MUL,
        BK_DIV
    } back_state_t;

endpackage

// File: hw/rtl/mafu_front.sv
// Front end: accepts requests, holds the latency registers and classifies each request.
// Depends on mafu_pkg.
module mafu_front
    import mafu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int TAG_WIDTH  = 16,
    parameter int IN_TDATA_W = 88
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LAT_W-1:0]       cfg_wdata,
    input  logic                   q_full,
    output logic                   push,
    output issue_ctrl_t            ctrl,
    output logic [DATA_WIDTH-1:0]  operand_a,
    output logic [DATA_WIDTH-1:0]  operand_b,
    output logic [TAG_WIDTH-1:0]   issue_tag
);

    logic [LAT_W-1:0] simple_lat_reg;
    logic [LAT_W-1:0] mul_lat_reg;
    logic [LAT_W-1:0] div_lat_reg;
    logic [OPC_W-1:0] op_code;

    // Latency registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simple_lat_reg <= RST_SIMPLE_LAT;
            mul_lat_reg    <= RST_MUL_LAT;
            div_lat_reg    <= RST_DIV_LAT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SIMPLE_LAT: simple_lat_reg <= cfg_wdata;
                CFG_MUL_LAT:    mul_lat_reg    <= cfg_wdata;
                CFG_DIV_LAT:    div_lat_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Unpack the request
    assign op_code   = s_axis_tdata[OPC_W-1:0];
    assign operand_a = s_axis_tdata[OPC_W +: DATA_WIDTH];
    assign operand_b = s_axis_tdata[OPC_W + DATA_WIDTH +: DATA_WIDTH];
    assign issue_tag = s_axis_tdata[OPC_W + 2 * DATA_WIDTH +: TAG_WIDTH];

    // Take a request whenever the queue has room
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    // Classify and pick the latency
    always_comb
    begin
        ctrl.latency = simple_lat_reg;
        ctrl.kind    = KIND_BAD;
        if (s_axis_tuser)
        begin
            ctrl.kind = KIND_TICK;
        end
        else
        begin
            case (op_code)
                OPC_ADD,
                OPC_ADDI: ctrl.kind = KIND_ADD;
                OPC_SUB:  ctrl.kind = KIND_SUB;
                OPC_CMP:  ctrl.kind = KIND_CMP;
                OPC_MUL:
                begin
                    ctrl.kind    = KIND_MUL;
                    ctrl.latency = mul_lat_reg;
                end
                OPC_DIV:
                begin
                    ctrl.kind    = KIND_DIV;
                    ctrl.latency = div_lat_reg;
                end
                default:  ctrl.kind = KIND_BAD;
            endcase
        end
    end

endmodule

// File: hw/rtl/mafu_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on mafu_pkg for its depth.
module mafu_queue
    import mafu_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign rdata  = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mafu_back.sv
// Back end: holds the single-entry unit state, runs the shift-add multiplier and the
// restoring divider, counts ticks and drives the result register. Depends on mafu_pkg.
module mafu_back
    import mafu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int TAG_WIDTH  = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  issue_ctrl_t             ctrl,
    input  logic [DATA_WIDTH-1:0]   operand_a,
    input  logic [DATA_WIDTH-1:0]   operand_b,
    input  logic [TAG_WIDTH-1:0]    issue_tag,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [STATUS_W-1:0]     m_axis_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    back_state_t          state_reg, state_next;
    logic                 busy_reg, busy_next;
    logic [LAT_W-1:0]     ticks_reg, ticks_next;
    logic [DW-1:0]        held_value_reg, held_value_next;
    logic [TAG_WIDTH-1:0] held_tag_reg, held_tag_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [DW-1:0]        mul_acc_reg, mul_acc_next;
    logic [DW-1:0]        mcand_reg, mcand_next;
    logic [DW-1:0]        mplier_reg, mplier_next;
    logic [DW-1:0]        div_rem_reg, div_rem_next;
    logic [DW-1:0]        div_quo_reg, div_quo_next;
    logic [DW-1:0]        div_dvsr_reg, div_dvsr_next;
    logic                 div_neg_reg, div_neg_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [OUT_TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [OUT_VALUE_W-1:0] out_value_reg, out_value_next;

    logic                 needs_out;
    logic                 out_free;
    logic                 is_issue;
    logic                 start_mul;
    logic                 start_div;
    logic                 last_step;
    logic [DW-1:0]        mul_step_acc;
    logic [DW:0]          rem_shift;
    logic [DW:0]          rem_diff;
    logic                 rem_ge;
    logic [DW-1:0]        rem_step;
    logic [DW-1:0]        quo_step;
    logic [DW-1:0]        quo_signed;
    logic [DW-1:0]        mag_a;
    logic [DW-1:0]        mag_b;
    logic [DW-1:0]        cmp_value;

    // Decide whether the head request may leave the queue now
    assign is_issue  = (ctrl.kind != KIND_TICK);
    assign needs_out = is_issue ? (ctrl.kind == KIND_BAD || busy_reg)
                                : (busy_reg && ticks_reg <= 8'd1);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop       = (state_reg == BK_DISPATCH) && q_valid && (!needs_out || out_free);
    assign start_mul = pop && !busy_reg && ctrl.kind == KIND_MUL;
    assign start_div = pop && !busy_reg && ctrl.kind == KIND_DIV && operand_b != '0;
    assign last_step = (cnt_reg == CNT_W'(1));

    // Multiplier step: add the shifted multiplicand on a set multiplier bit
    assign mul_step_acc = mul_acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // Divider step: shift in one dividend bit and try to subtract
    assign rem_shift  = {div_rem_reg, div_quo_reg[DW-1]};
    assign rem_diff   = rem_shift - {1'b0, div_dvsr_reg};
    assign rem_ge     = !rem_diff[DW];
    assign rem_step   = rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
    assign quo_step   = {div_quo_reg[DW-2:0], rem_ge};
    assign quo_signed = div_neg_reg ? (~quo_step + 1'b1) : quo_step;

    // Operand magnitudes and signed compare
    assign mag_a = operand_a[DW-1] ? (~operand_a + 1'b1) : operand_a;
    assign mag_b = operand_b[DW-1] ? (~operand_b + 1'b1) : operand_b;

    always_comb
    begin
        if (operand_a == operand_b)
        begin
            cmp_value = '0;
        end
        else if ($signed(operand_a) > $signed(operand_b))
        begin
            cmp_value = DW'(1);
        end
        else
        begin
            cmp_value = '1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_DISPATCH:
            begin
                if (start_mul)
                begin
                    state_next = BK_MUL;
                end
                else if (start_div)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_MUL,
            BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = BK_DISPATCH;
                end
            end
            default: state_next = BK_DISPATCH;
        endcase
    end

    // Datapath and result register
    always_comb
    begin
        busy_next       = busy_reg;
        ticks_next      = ticks_reg;
        held_value_next = held_value_reg;
        held_tag_next   = held_tag_reg;
        cnt_next        = cnt_reg;
        mul_acc_next    = mul_acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_dvsr_next   = div_dvsr_reg;
        div_neg_next    = div_neg_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_value_next  = out_value_reg;

        case (state_reg)
            BK_DISPATCH:
            begin
                if (pop)
                begin
                    if (!is_issue)
                    begin
                        // Tick: count down or deliver the held result
                        if (busy_reg)
                        begin
                            if (ticks_reg <= 8'd1)
                            begin
                                busy_next       = 1'b0;
                                ticks_next      = '0;
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_DONE;
                                out_tag_next    = OUT_TAG_W'(held_tag_reg);
                                out_value_next  = OUT_VALUE_W'($signed(held_value_reg));
                            end
                            else
                            begin
                                ticks_next = ticks_reg - 1'b1;
                            end
                        end
                    end
                    else if (ctrl.kind == KIND_BAD || busy_reg)
                    begin
                        // Reject: bad opcode wins over busy
                        out_valid_next  = 1'b1;
                        out_status_next = (ctrl.kind == KIND_BAD) ? STATUS_BAD_OPCODE
                                                                   : STATUS_BUSY;
                        out_tag_next    = OUT_TAG_W'(issue_tag);
                        out_value_next  = '0;
                    end
                    else
                    begin
                        // Valid issue: occupy the unit
                        busy_next     = 1'b1;
                        ticks_next    = ctrl.latency;
                        held_tag_next = issue_tag;
                        case (ctrl.kind)
                            KIND_ADD: held_value_next = operand_a + operand_b;
                            KIND_SUB: held_value_next = operand_a - operand_b;
                            KIND_CMP: held_value_next = cmp_value;
                            KIND_MUL:
                            begin
                                mul_acc_next = '0;
                                mcand_next   = operand_a;
                                mplier_next  = operand_b;
                                cnt_next     = CNT_W'(DW);
                            end
                            KIND_DIV:
                            begin
                                if (operand_b == '0)
                                begin
                                    held_value_next = '1;
                                end
                                else
                                begin
                                    div_rem_next  = '0;
                                    div_quo_next  = mag_a;
                                    div_dvsr_next = mag_b;
                                    div_neg_next  = operand_a[DW-1] ^ operand_b[DW-1];
                                    cnt_next      = CNT_W'(DW);
                                end
                            end
                            default: held_value_next = held_value_reg;
                        endcase
                    end
                end
            end
            BK_MUL:
            begin
                mul_acc_next = mul_step_acc;
                mcand_next   = {mcand_reg[DW-2:0], 1'b0};
                mplier_next  = {1'b0, mplier_reg[DW-1:1]};
                cnt_next     = cnt_reg - 1'b1;
                if (last_step)
                begin
                    held_value_next = mul_step_acc;
                end
            end
            BK_DIV:
            begin
                div_rem_next = rem_step;
                div_quo_next = quo_step;
                cnt_next     = cnt_reg - 1'b1;
                if (last_step)
                begin
                    held_value_next = quo_signed;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_DISPATCH;
            busy_reg      <= 1'b0;
            ticks_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            ticks_reg     <= ticks_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held_value_reg <= held_value_next;
        held_tag_reg   <= held_tag_next;
        mul_acc_reg    <= mul_acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        div_dvsr_reg   <= div_dvsr_next;
        div_neg_reg    <= div_neg_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_value_reg  <= out_value_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {out_value_reg, out_tag_reg};

endmodule

// File: hw/rtl/multicycle_alu_functional_unit.sv
// Multicycle ALU functional unit: single-entry integer unit with per-class latency (simple, multiply, divide).
// Usage:
//   Request channel s_axis_*: tuser is 1 for a tick, 0 for an issue. An issue carries
//   opcode, two operands and a tag in tdata. Result channel m_axis_*: tuser is the status
//   (done, bad opcode, busy), tdata the tag and the 32-bit value.
//   Latencies are set through cfg_we/cfg_addr/cfg_wdata while the unit is idle.
//   Requests pass a two-entry queue; the back end takes one request per cycle for ticks,
//   rejects and add/sub/compare issues while no stalled result blocks a request that must
//   produce one. A multiply or nonzero divide holds the back end, one bit per cycle in the
//   shift-add multiplier or restoring divider, while the queue fills and s_axis_tready drops.
//   A request's result reaches m_axis from its queue entry through the result register.
//   Only ticks deliver completed results; the result is held until the configured number
//   of ticks has passed.
//   Reset clears the unit to idle, empties the queue and restores latencies 1, 5, 15.
//   When the receiver stalls, the result register holds and the back end waits on any
//   request that needs to produce a result; other requests keep flowing.
// Depends on mafu_pkg, mafu_front, mafu_queue and mafu_back.
module multicycle_alu_functional_unit
    import mafu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int TAG_WIDTH  = 16,
    localparam int IN_TDATA_W = ((OPC_W + 2 * DATA_WIDTH + TAG_WIDTH + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // op_code, operand_a, operand_b, issue_tag
    input  logic                    s_axis_tuser,   // operation
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // result_tag, value
    output logic [STATUS_W-1:0]     m_axis_tuser,   // status
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [LAT_W-1:0]        cfg_wdata
);

    localparam int CTRL_W  = $bits(issue_ctrl_t);
    localparam int ENTRY_W = CTRL_W + 2 * DATA_WIDTH + TAG_WIDTH;

    logic                  push;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    issue_ctrl_t           f_ctrl;
    logic [DATA_WIDTH-1:0] f_a;
    logic [DATA_WIDTH-1:0] f_b;
    logic [TAG_WIDTH-1:0]  f_tag;
    logic [ENTRY_W-1:0]    q_wdata;
    logic [ENTRY_W-1:0]    q_rdata;
    issue_ctrl_t           b_ctrl;
    logic [DATA_WIDTH-1:0] b_a;
    logic [DATA_WIDTH-1:0] b_b;
    logic [TAG_WIDTH-1:0]  b_tag;

    mafu_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .TAG_WIDTH  (TAG_WIDTH),
        .IN_TDATA_W (IN_TDATA_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .push          (push),
        .ctrl          (f_ctrl),
        .operand_a     (f_a),
        .operand_b     (f_b),
        .issue_tag     (f_tag)
    );

    // Pack and unpack queue entries
    assign q_wdata = {f_ctrl, f_a, f_b, f_tag};
    assign b_ctrl  = issue_ctrl_t'(q_rdata[ENTRY_W-1 -: CTRL_W]);
    assign b_a     = q_rdata[TAG_WIDTH + DATA_WIDTH +: DATA_WIDTH];
    assign b_b     = q_rdata[TAG_WIDTH +: DATA_WIDTH];
    assign b_tag   = q_rdata[TAG_WIDTH-1:0];

    mafu_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    mafu_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .ctrl          (b_ctrl),
        .operand_a     (b_a),
        .operand_b     (b_b),
        .issue_tag     (b_tag),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: hw/rtl/mafu_checker.sv
// Port-level checks for the multicycle ALU functional unit, bound to the top level.
// Depends on mafu_pkg and multicycle_alu_functional_unit.
module mafu_props
    import mafu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [STATUS_W-1:0]     m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STATUS_DONE || m_axis_tuser == STATUS_BAD_OPCODE
                           || m_axis_tuser == STATUS_BUSY))
        else $error("undefined status code");

    // Rejected requests carry a zero value
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_DONE
        |-> m_axis_tdata[OUT_TAG_W +: OUT_VALUE_W] == '0)
        else $error("rejected request with nonzero value");

    // Queue fills only by accepting a request
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("request ready dropped without an accept");

endmodule

bind multicycle_alu_functional_unit mafu_props u_mafu_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/mafu_tb_pkg.sv
// Request encodings and field layout shared by the ALU unit checker and testbench.
// Depends on mafu_pkg for the opcode and field widths.
package mafu_tb_pkg;

    import mafu_pkg::*;

    // Operand and tag widths of the unit as built
    localparam int DW = 32;
    localparam int TW = 16;
    localparam int IN_TDATA_W = ((OPC_W + 2 * DW + TW + 7) / 8) * 8;

    // Request kind carried in s_axis_tuser
    typedef enum logic {
        REQ_ISSUE = 1'b0,
        REQ_TICK  = 1'b1
    } req_kind_t;

    // Opcodes outside the legal range
    localparam logic [OPC_W-1:0] OPC_NONE = 4'd0;
    localparam logic [OPC_W-1:0] OPC_TOP  = 4'd15;

    // Register index that selects no latency
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

endpackage

// File: dv/mafu_checker.sv
// Checker for the multicycle ALU unit: tracks latency writes and requests,
// predicts every result and compares it with the result channel. Depends on
// mafu_pkg and mafu_tb_pkg.
module mafu_checker
    import mafu_pkg::*;
    import mafu_tb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // op_code, operand_a, operand_b, issue_tag
    input  logic                    s_axis_tuser,   // operation
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // result_tag, value
    input  logic [STATUS_W-1:0]     m_axis_tuser,   // status
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [LAT_W-1:0]        cfg_wdata,
    output int                      mismatches,
    output int                      results_due,
    output int                      request_count,
    output int                      done_count,
    output int                      bad_count,
    output int                      busy_count
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TW-1:0]       tag;
        logic [DW-1:0]       value;
    } alu_result_t;

    // Shadow of the unit: latencies, single entry and pending results
    logic [LAT_W-1:0] simple_lat;
    logic [LAT_W-1:0] mul_lat;
    logic [LAT_W-1:0] div_lat;
    logic             unit_busy;
    logic [LAT_W-1:0] ticks_left;
    logic [DW-1:0]    held_value;
    logic [TW-1:0]    held_tag;
    alu_result_t      results_q[$];

    initial begin
        mismatches    = 0;
        results_due   = 0;
        request_count = 0;
        done_count    = 0;
        bad_count     = 0;
        busy_count    = 0;
    end

    // Divide rounding toward zero; zero divisor gives all ones, min / -1 wraps
    function automatic logic [DW-1:0] quotient(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW-1:0] mag_a;
        logic [DW-1:0] mag_b;
        logic [DW-1:0] q;
        if (b == '0)
            return '1;
        mag_a = a[DW-1] ? -a : a;
        mag_b = b[DW-1] ? -b : b;
        q = mag_a / mag_b;
        return (a[DW-1] ^ b[DW-1]) ? -q : q;
    endfunction

    // Three-way signed compare: 1, 0 or -1
    function automatic logic [DW-1:0] signed_order(input logic [DW-1:0] a,
                                                   input logic [DW-1:0] b);
        if ($signed(a) == $signed(b))
            return '0;
        return ($signed(a) > $signed(b)) ? DW'(1) : {DW{1'b1}};
    endfunction

    // Advance the shadow unit by one request and queue any result it causes
    task automatic alu_step(input req_kind_t kind, input logic [OPC_W-1:0] opc,
                            input logic [DW-1:0] a, input logic [DW-1:0] b,
                            input logic [TW-1:0] tag);
        logic [DW-1:0]    r;
        logic [LAT_W-1:0] lat;
        r = '0;
        lat = simple_lat;
        if (kind == REQ_TICK) begin
            if (unit_busy) begin
                if (ticks_left <= 1) begin
                    unit_busy = 1'b0;
                    ticks_left = '0;
                    results_q.push_back(alu_result_t'{STATUS_DONE, held_tag, held_value});
                end
                else
                    ticks_left = ticks_left - 1'b1;
            end
        end
        else if (opc == OPC_NONE || opc > OPC_CMP)
            results_q.push_back(alu_result_t'{STATUS_BAD_OPCODE, tag, '0});
        else if (unit_busy)
            results_q.push_back(alu_result_t'{STATUS_BUSY, tag, '0});
        else begin
            case (opc)
                OPC_ADD, OPC_ADDI: r = a + b;
                OPC_SUB:           r = a - b;
                OPC_MUL:
                begin
                    r = a * b;
                    lat = mul_lat;
                end
                OPC_DIV:
                begin
                    r = quotient(a, b);
                    lat = div_lat;
                end
                default:           r = signed_order(a, b);
            endcase
            held_value = r;
            held_tag = tag;
            ticks_left = lat;
            unit_busy = 1'b1;
        end
    endtask

    task automatic report(input string field, input logic [DW-1:0] want,
                          input logic [DW-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Retire results first, then take config writes and new requests
    always @(posedge clk or negedge rst_n) begin : track
        alu_result_t got;
        alu_result_t want;
        if (!rst_n) begin
            simple_lat = RST_SIMPLE_LAT;
            mul_lat = RST_MUL_LAT;
            div_lat = RST_DIV_LAT;
            unit_busy = 1'b0;
            ticks_left = '0;
            results_q.delete();
            results_due = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[OUT_TAG_W-1:0],
                       m_axis_tdata[OUT_TDATA_W-1:OUT_TAG_W]};
                if (results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got status %0d tag %h value %h",
                             $time, got.status, got.tag, got.value);
                end
                else begin
                    want = results_q.pop_front();
                    report("status", DW'(want.status), DW'(got.status));
                    report("tag", DW'(want.tag), DW'(got.tag));
                    report("value", want.value, got.value);
                    case (want.status)
                        STATUS_DONE:       done_count++;
                        STATUS_BAD_OPCODE: bad_count++;
                        default:           busy_count++;
                    endcase
                end
            end

            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SIMPLE_LAT: simple_lat = cfg_wdata;
                    CFG_MUL_LAT:    mul_lat = cfg_wdata;
                    CFG_DIV_LAT:    div_lat = cfg_wdata;
                    default:        ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                request_count++;
                alu_step(req_kind_t'(s_axis_tuser), s_axis_tdata[OPC_W-1:0],
                         s_axis_tdata[OPC_W+DW-1:OPC_W],
                         s_axis_tdata[OPC_W+2*DW-1:OPC_W+DW],
                         s_axis_tdata[OPC_W+2*DW+TW-1:OPC_W+2*DW]);
            end
            results_due = results_q.size();
        end
    end

endmodule

// File: dv/tb.sv
// Testbench top for the multicycle ALU unit: drives requests, latency writes and
// result back-pressure, and gives the verdict from the checker's counts.
// Depends on mafu_pkg, mafu_tb_pkg, mafu_checker and the unit RTL.
module tb;

    import mafu_pkg::*;
    import mafu_tb_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // op_code, operand_a, operand_b, issue_tag
    logic                    s_axis_tuser = 1'b0; // operation
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // result_tag, value
    logic [STATUS_W-1:0]     m_axis_tuser;        // status
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [LAT_W-1:0]        cfg_wdata = '0;

    int mismatches;
    int results_due;
    int request_count;
    int done_count;
    int bad_count;
    int busy_count;

    // Latencies currently written, used to size the drain at phase ends
    logic [LAT_W-1:0] lat_now [3];
    bit               send_calm = 1'b0;
    bit               sink_calm = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    multicycle_alu_functional_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    mafu_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .request_count (request_count),
        .done_count    (done_count),
        .bad_count     (bad_count),
        .busy_count    (busy_count)
    );

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input req_kind_t kind, input logic [OPC_W-1:0] opc,
                                input logic [DW-1:0] a, input logic [DW-1:0] b,
                                input logic [TW-1:0] tag);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_TDATA_W'({tag, b, a, opc});
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Ticks carry random payload, which the unit must ignore
    task automatic tick();
        send_request(REQ_TICK, OPC_W'($urandom), $urandom, $urandom, TW'($urandom));
    endtask

    task automatic issue(input logic [OPC_W-1:0] opc, input logic [DW-1:0] a,
                         input logic [DW-1:0] b, input logic [TW-1:0] tag);
        send_request(REQ_ISSUE, opc, a, b, tag);
    endtask

    task automatic write_lat(input logic [CFG_ADDR_W-1:0] idx, input logic [LAT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx != CFG_UNUSED)
            lat_now[idx] = val;
    endtask

    // Tick the entry empty, wait for every result, then let the pipe go quiet
    task automatic settle();
        int n;
        n = 1;
        foreach (lat_now[i])
            if (lat_now[i] > n)
                n = lat_now[i];
        repeat (n) tick();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // Operands biased toward the edges of the signed range
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DW'(1);
            2:       return '1;
            3:       return {1'b1, {(DW-1){1'b0}}};
            4:       return {1'b0, {(DW-1){1'b1}}};
            5:       return DW'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Mostly issue-then-tick traffic, with bad opcodes and busy collisions mixed in
    task automatic random_phase(input int count, input int tick_pct);
        int k;
        repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct)
                tick();
            else if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 9);
                issue((k == 0) ? OPC_NONE : OPC_W'(OPC_CMP + k), $urandom, $urandom,
                      TW'($urandom));
            end
            else
                issue(OPC_W'($urandom_range(OPC_ADD, OPC_CMP)), pick_operand(),
                      pick_operand(), TW'($urandom));
        end
    endtask

    // Drop the result ready for a random stall after each accepted result
    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                stall = sink_calm ? 0 : $urandom_range(0, 8);
            end
        end
    end

    initial begin : stimulus
        int simple_set [5];
        int mul_set [5];
        int div_set [5];
        int phase_len [5];
        int phase_ticks [5];
        simple_set  = '{RST_SIMPLE_LAT, 0, 255, 3, $urandom_range(1, 20)};
        mul_set     = '{RST_MUL_LAT, 0, 255, 1, $urandom_range(1, 20)};
        div_set     = '{RST_DIV_LAT, 0, 255, 7, $urandom_range(1, 20)};
        phase_len   = '{150, 100, 300, 100, 100};
        phase_ticks = '{55, 50, 93, 55, 60};
        lat_now = '{RST_SIMPLE_LAT, RST_MUL_LAT, RST_DIV_LAT};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every opcode and corner at the shortest latencies
        write_lat(CFG_SIMPLE_LAT, 8'd1);
        write_lat(CFG_MUL_LAT, 8'd1);
        write_lat(CFG_DIV_LAT, 8'd1);
        issue(OPC_ADD, 32'h7fff_ffff, 32'h0000_0001, 16'hffff);
        tick();
        issue(OPC_ADDI, 32'hffff_ffff, 32'h8000_0000, 16'h0000);
        tick();
        issue(OPC_SUB, 32'h8000_0000, 32'h0000_0001, 16'h8001);
        tick();
        // compare where a plain subtraction would overflow
        issue(OPC_CMP, 32'h8000_0000, 32'h7fff_ffff, 16'h0001);
        tick();
        issue(OPC_CMP, 32'h7fff_ffff, 32'h8000_0000, 16'h0002);
        tick();
        issue(OPC_CMP, 32'h1234_5678, 32'h1234_5678, 16'h0003);
        tick();
        issue(OPC_MUL, 32'hffff_fffd, 32'h7fff_ffff, 16'h0004);
        tick();
        // divide by zero, minimum over minus one, rounding of a negative quotient
        issue(OPC_DIV, 32'h0000_1234, 32'h0000_0000, 16'h0005);
        tick();
        issue(OPC_DIV, 32'h8000_0000, 32'hffff_ffff, 16'h0006);
        tick();
        issue(OPC_DIV, 32'hffff_fff9, 32'h0000_0002, 16'h0007);
        tick();
        issue(OPC_NONE, 32'h0000_0001, 32'h0000_0002, 16'h0008);
        issue(OPC_TOP, 32'h0000_0003, 32'h0000_0004, 16'h0009);
        // second issue lands while the entry is occupied
        issue(OPC_ADD, 32'h0000_0005, 32'h0000_0006, 16'h000a);
        issue(OPC_SUB, 32'h0000_0001, 32'h0000_0002, 16'h000b);
        tick();
        tick();
        settle();

        // Random phases over reset, zero, maximum and mixed latencies
        for (int p = 0; p < 5; p++) begin
            write_lat(CFG_SIMPLE_LAT, LAT_W'(simple_set[p]));
            write_lat(CFG_MUL_LAT, LAT_W'(mul_set[p]));
            write_lat(CFG_DIV_LAT, LAT_W'(div_set[p]));
            if (p == 3)
                write_lat(CFG_UNUSED, LAT_W'($urandom));
            random_phase(phase_len[p], phase_ticks[p]);
            settle();
        end

        $display("Ran %0d requests over 6 latency settings, including zero and 255.",
                 request_count);
        $display("Checked %0d completions, %0d bad-opcode and %0d busy rejections.",
                 done_count, bad_count, busy_count);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
